FILE: hw/rtl/best_fit_partition_allocator_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define BFPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bfpa_pkg.sv
package bfpa_pkg;

    localparam int AMT_W   = 20;
    localparam int PIDX_W  = 6;
    localparam int CFG_W   = 7;
    localparam int ENTRY_W = AMT_W + 1;

    localparam logic [AMT_W-1:0] CAP_LIMIT = AMT_W'(1000000);

    localparam logic [1:0] KIND_LOAD     = 2'd0;
    localparam logic [1:0] KIND_ALLOC    = 2'd1;
    localparam logic [1:0] KIND_REASSIGN = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PIDX_W-1:0] part_index;
        logic [AMT_W-1:0]  amount;
    } req_t;

    typedef struct packed {
        logic              granted;
        logic [PIDX_W-1:0] chosen_part;
        logic [CFG_W-1:0]  allowed_count;
    } rsp_t;

    typedef struct packed {
        logic ge;
        logic le;
    } cmp_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RS_RD,
        ST_RS_CHK,
        ST_DONE
    } seq_state_t;

endpackage

FILE: hw/rtl/bfpa_chan_if.sv
interface bfpa_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/best_fit_partition_allocator_unit.sv
// Channel   Role     Payload                                   Moves when
// req       sink     kind, part_index, amount                  valid && ready
// rsp       source   granted, chosen_part, allowed_count       valid && ready
// cfg       sink     partitions_in_use (7 bits)                valid && ready
//
// Flow: a load, an unknown kind or a reassign of an unsearched entry goes
// straight to the result; any other reassign first reads and checks its
// entry; an allocate makes one table read per searched entry through the
// single read port, the searched entry count being n, and a grant then
// marks the winner occupied before the result is offered.
// Reset: a clearing pass marks every entry occupied; req
// stays not ready during it, cfg is taken at any time.
// Stalls: a finished result waits in the output register while the next item
// is accepted; a second result waits in the sequencer until rsp drains.
module best_fit_partition_allocator_unit
    import bfpa_pkg::*;
#(
    parameter int PARTITIONS = 64,
    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    bfpa_chan_if.sink   req,
    bfpa_chan_if.source rsp,
    bfpa_chan_if.sink   cfg
);

    logic [CFG_W-1:0]   cfg_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_payload_reg;

    logic               rsp_free;
    logic               res_valid;
    rsp_t               res_payload;

    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata;
    logic               tbl_re;
    logic [IDX_W-1:0]   tbl_raddr;
    logic [ENTRY_W-1:0] tbl_rdata;

    logic [AMT_W-1:0]   cmp_cap;
    logic [AMT_W-1:0]   cmp_amount;
    logic [AMT_W-1:0]   cmp_best;
    cmp_res_t           cmp_res;

    // Config register: always writable.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            cfg_reg <= cfg.payload;
        end
    end

    // Output register: free when empty or being drained this cycle.
    assign rsp_free    = !rsp_valid_reg || rsp.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Payload register: load on handoff, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (res_valid && rsp_free)
        begin
            rsp_payload_reg <= res_payload;
        end
    end

    bfpa_seq #(
        .PARTITIONS (PARTITIONS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_payload (req.payload),
        .req_ready   (req.ready),
        .cfg_count   (cfg_reg),
        .rsp_free    (rsp_free),
        .res_valid   (res_valid),
        .res_payload (res_payload),
        .tbl_we      (tbl_we),
        .tbl_waddr   (tbl_waddr),
        .tbl_wdata   (tbl_wdata),
        .tbl_re      (tbl_re),
        .tbl_raddr   (tbl_raddr),
        .tbl_rdata   (tbl_rdata),
        .cmp_cap     (cmp_cap),
        .cmp_amount  (cmp_amount),
        .cmp_best    (cmp_best),
        .cmp_res     (cmp_res)
    );

    // Partition table: capacity and free flag per entry.
    bfpa_table #(
        .PARTITIONS (PARTITIONS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Shared compare unit for the allocate scan and the reassign check.
    bfpa_cmp_unit u_cmp (
        .cap    (cmp_cap),
        .amount (cmp_amount),
        .best   (cmp_best),
        .res    (cmp_res)
    );

endmodule

FILE: hw/rtl/bfpa_table.sv
module bfpa_table
    import bfpa_pkg::*;
#(
    parameter int PARTITIONS = 64,
    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1
) (
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [IDX_W-1:0]   raddr,
    output logic [ENTRY_W-1:0] rdata
);

    // Entry layout: free flag on top, capacity below.
    logic [ENTRY_W-1:0] mem [PARTITIONS];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bfpa_cmp_unit.sv
module bfpa_cmp_unit
    import bfpa_pkg::*;
(
    input  logic [AMT_W-1:0] cap,
    input  logic [AMT_W-1:0] amount,
    input  logic [AMT_W-1:0] best,
    output cmp_res_t         res
);

    assign res.ge = (cap >= amount);
    assign res.le = (cap <= best);

endmodule

FILE: hw/rtl/bfpa_seq.sv
module bfpa_seq
    import bfpa_pkg::*;
#(
    parameter int PARTITIONS = 64,
    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
    localparam int CNT_W = $clog2(PARTITIONS + 1),
    localparam int XW    = (CNT_W > CFG_W) ? CNT_W : CFG_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  req_t               req_payload,
    output logic               req_ready,
    input  logic [CFG_W-1:0]   cfg_count,
    input  logic               rsp_free,
    output logic               res_valid,
    output rsp_t               res_payload,
    output logic               tbl_we,
    output logic [IDX_W-1:0]   tbl_waddr,
    output logic [ENTRY_W-1:0] tbl_wdata,
    output logic               tbl_re,
    output logic [IDX_W-1:0]   tbl_raddr,
    input  logic [ENTRY_W-1:0] tbl_rdata,
    output logic [AMT_W-1:0]   cmp_cap,
    output logic [AMT_W-1:0]   cmp_amount,
    output logic [AMT_W-1:0]   cmp_best,
    input  cmp_res_t           cmp_res
);

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    logic [AMT_W-1:0]  amount_reg, amount_next;
    logic [AMT_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic              found_reg, found_next;
    logic [CFG_W-1:0]  count_reg, count_next;
    rsp_t              res_reg, res_next;

    logic [XW-1:0]     part_x;
    logic [XW-1:0]     cfg_x;
    logic [XW-1:0]     n_x;
    logic [CNT_W-1:0]  n_cnt;
    logic [XW-1:0]     req_idx_x;
    logic [XW-1:0]     idx_x;
    logic              rd_free;

    // Number of entries searched: register value clipped at table depth.
    assign part_x    = XW'(PARTITIONS);
    assign cfg_x     = XW'(cfg_count);
    assign n_x       = (cfg_x > part_x) ? part_x : cfg_x;
    assign n_cnt     = n_x[CNT_W-1:0];
    assign req_idx_x = XW'(req_payload.part_index);
    assign idx_x     = XW'(idx_reg);
    assign rd_free   = tbl_rdata[AMT_W];

    assign cmp_cap    = tbl_rdata[AMT_W-1:0];
    assign cmp_amount = amount_reg;
    assign cmp_best   = best_reg;

    assign res_payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= pidx_next;
        idx_reg    <= idx_next;
        amount_reg <= amount_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        found_reg  <= found_next;
        count_reg  <= count_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        idx_next    = idx_reg;
        amount_next = amount_reg;
        best_next   = best_reg;
        pick_next   = pick_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        res_next    = res_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = cnt_reg[IDX_W-1:0];
        tbl_wdata   = '0;
        tbl_re      = 1'b0;
        tbl_raddr   = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every entry to occupied after reset.
                tbl_we = 1'b1;
                if (cnt_reg == CNT_W'(PARTITIONS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    idx_next    = req_payload.part_index;
                    amount_next = req_payload.amount;
                    best_next   = CAP_LIMIT;
                    found_next  = 1'b0;
                    count_next  = '0;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    res_next    = '0;
                    unique case (req_payload.kind)
                        KIND_LOAD:
                        begin
                            if (req_idx_x < part_x)
                            begin
                                tbl_we    = 1'b1;
                                tbl_waddr = req_idx_x[IDX_W-1:0];
                                tbl_wdata = {1'b1, req_payload.amount};
                            end
                            res_next.granted     = 1'b1;
                            res_next.chosen_part = req_payload.part_index;
                            state_next           = ST_DONE;
                        end
                        KIND_ALLOC:
                        begin
                            state_next = ST_SCAN;
                        end
                        KIND_REASSIGN:
                        begin
                            state_next = (req_idx_x < n_x) ? ST_RS_RD : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Judge the entry read last cycle.
                if (pend_reg)
                begin
                    if (rd_free && cmp_res.ge && cmp_res.le)
                    begin
                        best_next  = cmp_cap;
                        pick_next  = pidx_reg;
                        found_next = 1'b1;
                    end
                    if (!rd_free && cmp_res.ge)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                // Issue the next read while entries remain.
                if (cnt_reg < n_cnt)
                begin
                    tbl_re    = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (found_reg)
                        begin
                            state_next = ST_COMMIT;
                        end
                        else
                        begin
                            res_next.allowed_count = count_reg;
                            state_next             = ST_DONE;
                        end
                    end
                end
            end

            ST_COMMIT:
            begin
                // Mark the winner occupied; its capacity is the best seen.
                tbl_we               = 1'b1;
                tbl_waddr            = pick_reg;
                tbl_wdata            = {1'b0, best_reg};
                res_next.granted     = 1'b1;
                res_next.chosen_part = PIDX_W'(XW'(pick_reg));
                state_next           = ST_DONE;
            end

            ST_RS_RD:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = idx_x[IDX_W-1:0];
                state_next = ST_RS_CHK;
            end

            ST_RS_CHK:
            begin
                if (!rd_free && cmp_res.ge)
                begin
                    res_next.granted     = 1'b1;
                    res_next.chosen_part = idx_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bfpa_checker.sv
`include "best_fit_partition_allocator_unit_defines.svh"

module bfpa_checker
    import bfpa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_granted,
    input logic [PIDX_W-1:0] rsp_chosen_part,
    input logic [CFG_W-1:0]  rsp_allowed_count
);

    // Hold a result until it is taken.
    `BFPA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

    // One item at a time: busy right after an accept.
    `BFPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "req ready after accept")

    // A refusal names no partition.
    `BFPA_ASSERT_SAME(a_refuse_no_part, clk, rst_n, rsp_valid && !rsp_granted, rsp_chosen_part == '0, "refusal with partition")

    // A count only comes with a failed allocate.
    `BFPA_ASSERT_SAME(a_count_on_fail, clk, rst_n, rsp_valid && (rsp_allowed_count != '0), !rsp_granted, "count on grant")

endmodule

bind best_fit_partition_allocator_unit bfpa_checker u_bfpa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_granted       (rsp.payload.granted),
    .rsp_chosen_part   (rsp.payload.chosen_part),
    .rsp_allowed_count (rsp.payload.allowed_count)
);
